// ----- design/hbe_pkg.sv -----
// Shared types, codes and sizing constants for the Huffman byte encoder.
// No dependencies; imported by every design module.
package hbe_pkg;

    // Sizing
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int CNT_W        = 3;
    localparam int PEND_W       = 7;
    localparam int TOT_W        = 48;
    localparam int RESULT_LIMIT = 4;
    localparam int IDX_W        = $clog2(RESULT_LIMIT);
    localparam int NUM_W        = $clog2(RESULT_LIMIT + 1);
    // Pending bits plus one full code word
    localparam int ACC_W        = MAX_CODE_LEN + PEND_W;
    localparam int SUM_W        = $clog2(ACC_W + 1);
    // Accumulator with room below it so every byte select stays in range
    localparam int AL_W         = ACC_W + 8 * RESULT_LIMIT;

    // Item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_PACKED  = 2'd0;
    localparam logic [1:0] ST_FLUSH   = 2'd1;
    localparam logic [1:0] ST_NO_CODE = 2'd2;
    localparam logic [1:0] ST_BAD_LEN = 2'd3;

    // Table read data for the item in the packing stage
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;     // zero when the symbol has no code
    } tbl_rd_t;

    // All results caused by one item
    typedef struct packed {
        logic [NUM_W-1:0]                 num;     // 0 .. RESULT_LIMIT, zero when the item has no result
        logic [1:0]                       status;
        logic [RESULT_LIMIT-1:0][7:0]     bytes;   // element 0 goes out first
        logic                             present;
        logic [TOT_W-1:0]                 total;
    } rec_t;

endpackage

// ----- design/huffman_byte_encoder_core.sv -----
// Huffman byte encoder top level: code table, packing stage and output register.
// Depends on hbe_pkg, hbe_code_table, hbe_packer, hbe_out_buffer.
//
// Takes one item per cycle: load a symbol's code, encode a byte, or flush.
// An item is accepted while the packing stage is empty or retiring, so items
// stream at one per cycle. The transfer edge loads the table read register and
// the packing stage together; the packing stage works out the item in the next
// cycle and loads the output register once that register is free, and the
// first result is offered from the output register.
// An item that gives k results (up to four packed bytes from one encode) holds
// the single output register for k transfers; input stalls behind it only when
// the packing stage also holds an item with results. In-range loads and encodes
// that complete no byte give no result and never wait on the output. No clearing
// pass is needed after reset: per-symbol valid bits mark unloaded codes.
module huffman_byte_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_symbol,
    input  logic [31:0] s_code_word,
    input  logic [5:0]  s_code_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_present,
    output logic [47:0] m_total_bits,
    output logic        m_last
);
    import hbe_pkg::*;

    tbl_rd_t rd;
    rec_t    rec;
    logic    in_xfer;
    logic    rec_load;
    logic    rec_free;

    assign in_xfer = s_valid && s_ready;

    hbe_code_table u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_xfer     (in_xfer),
        .kind        (s_kind),
        .symbol      (s_symbol),
        .code_word   (s_code_word),
        .code_length (s_code_length),
        .rd          (rd)
    );

    hbe_packer u_packer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_xfer     (in_xfer),
        .kind        (s_kind),
        .code_length (s_code_length),
        .rd          (rd),
        .rec_free    (rec_free),
        .in_ready    (s_ready),
        .rec_load    (rec_load),
        .rec         (rec)
    );

    hbe_out_buffer u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .rec_load       (rec_load),
        .rec            (rec),
        .rec_free       (rec_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_byte     (m_out_byte),
        .m_byte_present (m_byte_present),
        .m_total_bits   (m_total_bits),
        .m_last         (m_last)
    );

endmodule

// ----- design/hbe_code_table.sv -----
// Code table: code word memory, length memory and per-symbol valid bits.
// Depends on hbe_pkg. Loads with len <= 32 write; registered read on each transfer.
module hbe_code_table (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_xfer,
    input  logic [1:0]                kind,
    input  logic [7:0]                symbol,
    input  logic [31:0]               code_word,
    input  logic [5:0]                code_length,
    output hbe_pkg::tbl_rd_t          rd
);
    import hbe_pkg::*;

    logic [CODE_W-1:0]       code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;

    logic [CODE_W-1:0] rd_code_reg;
    logic [LEN_W-1:0]  rd_len_reg;
    logic              rd_valid_reg;

    logic [SYM_W-1:0] addr;
    logic             sym_ok;
    logic             wr_en;

    assign addr   = symbol[SYM_W-1:0];
    assign sym_ok = {1'b0, symbol} < 9'(SYMBOL_COUNT);
    assign wr_en  = in_xfer && (kind == KIND_LOAD) && sym_ok &&
                    ({1'b0, code_length} <= 7'(MAX_CODE_LEN));

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            code_mem[addr] <= code_word;
            len_mem[addr]  <= code_length;
        end
        if (in_xfer) begin
            rd_code_reg <= code_mem[addr];
            rd_len_reg  <= len_mem[addr];
        end
    end

    // Valid bits stand in for the all-zero reset of the length store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[addr] <= 1'b1;
            end
            if (in_xfer) begin
                rd_valid_reg <= valid_reg[addr] && sym_ok;
            end
        end
    end

    assign rd.code = rd_code_reg;
    assign rd.len  = rd_valid_reg ? rd_len_reg : '0;

endmodule

// ----- design/hbe_packer.sv -----
// Packing stage: holds one item with its table data, packs code bits into bytes,
// keeps pending bits and the bit total. Depends on hbe_pkg.
module hbe_packer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_xfer,
    input  logic [1:0]                kind,
    input  logic [5:0]                code_length,
    input  hbe_pkg::tbl_rd_t          rd,
    input  logic                      rec_free,
    output logic                      in_ready,
    output logic                      rec_load,
    output hbe_pkg::rec_t             rec
);
    import hbe_pkg::*;

    // Stage registers
    logic             s1_valid_reg;
    logic [1:0]       s1_kind_reg;
    logic [LEN_W-1:0] s1_len_reg;

    // Packing state
    logic [PEND_W-1:0] pend_reg,  pend_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [TOT_W-1:0]  total_reg, total_next;

    logic [CODE_W-1:0] code_mask;
    logic [ACC_W-1:0]  acc;
    logic [SUM_W-1:0]  tot;
    logic [AL_W-1:0]   aligned;
    logic [SUM_W-4:0]  nbytes;
    logic [NUM_W-1:0]  num;
    logic [TOT_W:0]    sum;
    logic [7:0]        padded;
    logic              commit;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_kind_reg <= kind;
            s1_len_reg  <= code_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            pend_reg     <= '0;
            cnt_reg      <= '0;
            total_reg    <= '0;
        end else begin
            if (in_xfer) begin
                s1_valid_reg <= 1'b1;
            end else if (commit) begin
                s1_valid_reg <= 1'b0;
            end
            if (commit) begin
                pend_reg  <= pend_next;
                cnt_reg   <= cnt_next;
                total_reg <= total_next;
            end
        end
    end

    // Shift the code into the pending bits and left-align for byte selection
    assign code_mask = ~({CODE_W{1'b1}} << rd.len);
    assign acc       = (ACC_W'(pend_reg) << rd.len) | ACC_W'(rd.code & code_mask);
    assign tot       = SUM_W'(cnt_reg) + SUM_W'(rd.len);
    assign aligned   = {acc, {(8 * RESULT_LIMIT){1'b0}}} << (SUM_W'(ACC_W) - tot);
    assign nbytes    = tot[SUM_W-1:3];
    assign num       = ({1'b0, nbytes} > (SUM_W-2)'(RESULT_LIMIT)) ?
                       NUM_W'(RESULT_LIMIT) : NUM_W'(nbytes);
    assign sum       = {1'b0, total_reg} + (TOT_W+1)'(rd.len);
    assign padded    = 8'({1'b0, pend_reg} << (4'd8 - 4'(cnt_reg)));

    // Per-kind results and next state
    always_comb begin
        rec        = '0;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        for (int k = 0; k < RESULT_LIMIT; k++) begin
            rec.bytes[k] = aligned[AL_W-1-8*k -: 8];
        end
        case (s1_kind_reg)
            KIND_LOAD: begin
                if ({1'b0, s1_len_reg} > 7'(MAX_CODE_LEN)) begin
                    rec.num    = NUM_W'(1);
                    rec.status = ST_BAD_LEN;
                    rec.bytes  = '0;
                end
            end
            KIND_ENCODE: begin
                if (rd.len == '0) begin
                    rec.num    = NUM_W'(1);
                    rec.status = ST_NO_CODE;
                    rec.bytes  = '0;
                end else begin
                    rec.num     = num;
                    rec.status  = ST_PACKED;
                    rec.present = 1'b1;
                    pend_next   = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << tot[2:0]);
                    cnt_next    = tot[2:0];
                    total_next  = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
                end
            end
            KIND_FLUSH: begin
                rec.num      = NUM_W'(1);
                rec.status   = ST_FLUSH;
                rec.bytes    = '0;
                rec.bytes[0] = padded;
                rec.present  = (cnt_reg != '0);
                rec.total    = total_reg;
                pend_next    = '0;
                cnt_next     = '0;
                total_next   = '0;
            end
            default: begin
            end
        endcase
    end

    // Items without results retire even while the output is busy
    assign commit   = s1_valid_reg && ((rec.num == '0) || rec_free);
    assign rec_load = commit && (rec.num != '0);
    assign in_ready = !s1_valid_reg || commit;

endmodule

// ----- design/hbe_out_buffer.sv -----
// Output register: holds the results of one item and sends them one per transfer.
// Depends on hbe_pkg.
module hbe_out_buffer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rec_load,
    input  hbe_pkg::rec_t             rec,
    output logic                      rec_free,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [7:0]                m_out_byte,
    output logic                      m_byte_present,
    output logic [47:0]               m_total_bits,
    output logic                      m_last
);
    import hbe_pkg::*;

    rec_t             rec_reg;
    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             is_last;
    logic             done;

    assign is_last  = (NUM_W'(idx_reg) + NUM_W'(1)) == rec_reg.num;
    assign done     = valid_reg && m_ready && is_last;
    assign rec_free = !valid_reg || done;

    always_ff @(posedge aclk) begin
        if (rec_load) begin
            rec_reg <= rec;
        end
    end

    // Result index within the held item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (rec_load) begin
                valid_reg <= 1'b1;
                idx_reg   <= '0;
            end else if (done) begin
                valid_reg <= 1'b0;
                idx_reg   <= '0;
            end else if (valid_reg && m_ready) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    assign m_valid        = valid_reg;
    assign m_status       = rec_reg.status;
    assign m_out_byte     = rec_reg.bytes[idx_reg];
    assign m_byte_present = rec_reg.present;
    assign m_total_bits   = rec_reg.total;
    assign m_last         = is_last;

endmodule

// ----- dv/hbe_stream_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the Huffman byte encoder: watches both channels, keeps its own
// code table and MSB-first bit packer, and compares every result transfer.
// Depends on hbe_pkg.
module hbe_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_symbol,
    input  logic [31:0] s_code_word,
    input  logic [5:0]  s_code_length,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [7:0]  m_out_byte,
    input  logic        m_byte_present,
    input  logic [47:0] m_total_bits,
    input  logic        m_last,
    output int          error_count,
    output int          results_owed
);
    import hbe_pkg::*;

    localparam logic [TOT_W-1:0] TOTAL_ALL = '1;

    typedef struct {
        logic [1:0]       status;
        logic [7:0]       out_byte;
        logic             present;
        logic [TOT_W-1:0] total;
        logic             last;
    } enc_result_t;

    // Model state: code table and the partial byte of the current message
    logic [CODE_W-1:0] code_tbl [SYMBOL_COUNT];
    logic [LEN_W-1:0]  len_tbl  [SYMBOL_COUNT];
    logic [7:0]        held_bits;
    int                held_cnt;
    logic [TOT_W-1:0]  msg_bits;

    enc_result_t encoder_results_q [$];
    int          mismatches = 0;

    function automatic enc_result_t make_result(input logic [1:0] status,
                                                input logic [7:0] out_byte,
                                                input logic present,
                                                input logic [TOT_W-1:0] total);
        enc_result_t r;
        r.status   = status;
        r.out_byte = out_byte;
        r.present  = present;
        r.total    = total;
        r.last     = 1'b0;
        return r;
    endfunction

    // Work out the results of one accepted item and queue them in order
    task automatic pack_item(input logic [1:0] kind, input logic [7:0] sym,
                             input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
        enc_result_t res [$];
        logic [7:0]  cur;
        logic [7:0]  padded;
        int          cnt;
        int          clen;
        case (kind)
            KIND_LOAD: begin
                if (len > MAX_CODE_LEN) begin
                    res.insert(res.size(), make_result(ST_BAD_LEN, '0, 1'b0, '0));
                end else if (sym < SYMBOL_COUNT) begin
                    code_tbl[sym] = word;
                    len_tbl[sym]  = len;
                end
            end
            KIND_ENCODE: begin
                if (sym >= SYMBOL_COUNT || len_tbl[sym] == 0) begin
                    res.insert(res.size(), make_result(ST_NO_CODE, '0, 1'b0, '0));
                end else begin
                    clen = int'(len_tbl[sym]);
                    cur  = held_bits;
                    cnt  = held_cnt;
                    // shift code bits in, first bit first; emit each full byte
                    for (int i = clen - 1; i >= 0; i--) begin
                        cur = {cur[6:0], code_tbl[sym][i]};
                        cnt++;
                        if (cnt == 8) begin
                            if (res.size() < RESULT_LIMIT)
                                res.insert(res.size(),
                                           make_result(ST_PACKED, cur, 1'b1, '0));
                            cur = '0;
                            cnt = 0;
                        end
                    end
                    held_bits = cur;
                    held_cnt  = cnt;
                    // saturating bit count
                    if (TOTAL_ALL - msg_bits < clen)
                        msg_bits = TOTAL_ALL;
                    else
                        msg_bits = msg_bits + clen;
                end
            end
            KIND_FLUSH: begin
                padded = '0;
                if (held_cnt > 0)
                    padded = held_bits << (8 - held_cnt);
                res.insert(res.size(), make_result(ST_FLUSH, padded, held_cnt > 0, msg_bits));
                held_bits = '0;
                held_cnt  = 0;
                msg_bits  = '0;
            end
            default: ;
        endcase
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            encoder_results_q.insert(encoder_results_q.size(), res[i]);
    endtask

    task automatic check_field(input string name, input logic [TOT_W-1:0] want,
                               input logic [TOT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare result transfers, then predict from input transfers
    always @(posedge aclk) begin : watch
        enc_result_t want;
        if (!aresetn) begin
            foreach (code_tbl[i]) begin
                code_tbl[i] = '0;
                len_tbl[i]  = '0;
            end
            held_bits = '0;
            held_cnt  = 0;
            msg_bits  = '0;
            encoder_results_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (encoder_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d byte %0h",
                             $time, m_status, m_out_byte);
                    mismatches++;
                end else begin
                    want = encoder_results_q.pop_front();
                    check_field("status", TOT_W'(want.status), TOT_W'(m_status));
                    check_field("out_byte", TOT_W'(want.out_byte), TOT_W'(m_out_byte));
                    check_field("byte_present", TOT_W'(want.present),
                                TOT_W'(m_byte_present));
                    check_field("total_bits", want.total, m_total_bits);
                    check_field("last", TOT_W'(want.last), TOT_W'(m_last));
                end
            end
            if (s_valid && s_ready)
                pack_item(s_kind, s_symbol, s_code_word, s_code_length);
        end
        error_count  <= mismatches;
        results_owed <= encoder_results_q.size();
    end

endmodule

// ----- dv/tb_huffman_byte_encoder_core.sv -----
`timescale 1ns / 100ps
// Testbench top for huffman_byte_encoder_core: clock, reset, item stimulus with bursts
// and gaps, result-side stalls, watchdog and verdict. Uses hbe_pkg and hbe_stream_checker.
module tb_huffman_byte_encoder_core;
    import hbe_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;   // not a defined kind, block drops it
    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind        = '0;
    logic [7:0]  s_symbol      = '0;
    logic [31:0] s_code_word   = '0;
    logic [5:0]  s_code_length = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_out_byte;
    logic        m_byte_present;
    logic [47:0] m_total_bits;
    logic        m_last;

    int error_count;
    int results_owed;
    int burst_left  = 8;
    int idle_cycles = 0;
    bit hold_req    = 1'b0;

    huffman_byte_encoder_core i_dut (.*);

    hbe_stream_checker i_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // One input transfer; the sender goes quiet for a while at the end of a burst
    task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                             input logic [31:0] word, input logic [5:0] len);
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_symbol      <= sym;
        s_code_word   <= word;
        s_code_length <= len;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // Receiver: stall pattern in segments, plus one long hold-off on request
    initial begin : receiver
        int seg;
        int mode;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(1, 40);
            repeat (seg) begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= 1'b0;
                endcase
                @(posedge aclk);
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_huffman_byte_encoder_core NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int         sent;
        int         pick;
        int         nload;
        int         nenc;
        logic [7:0] sym;
        logic [5:0] len;
        logic [7:0] msg_syms [$];

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty flush, no-code encode, bad lengths, spare kind
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        send_item(KIND_ENCODE, 8'h41, 32'h0, 6'd0);
        send_item(KIND_LOAD, 8'h00, 32'h0, 6'd33);
        send_item(KIND_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd63);
        send_item(KIND_SPARE, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        // full-length code: four bytes from one encode
        send_item(KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
        send_item(KIND_ENCODE, 8'h00, 32'h0, 6'd0);
        // single-symbol code "0", fills no byte
        send_item(KIND_LOAD, 8'hFF, 32'h0, 6'd1);
        send_item(KIND_ENCODE, 8'hFF, 32'h0, 6'd0);
        // word bits above the length are dropped
        send_item(KIND_LOAD, 8'h80, 32'hFFFF_FFF5, 6'd3);
        send_item(KIND_ENCODE, 8'h80, 32'h0, 6'd0);
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        // exact byte, then the symbol is unloaded again
        send_item(KIND_LOAD, 8'h7F, 32'h0000_00A5, 6'd8);
        send_item(KIND_ENCODE, 8'h7F, 32'h0, 6'd0);
        send_item(KIND_LOAD, 8'h7F, 32'h0000_00A5, 6'd0);
        send_item(KIND_ENCODE, 8'h7F, 32'h0, 6'd0);
        // long codes back to back keep the output busy
        send_item(KIND_LOAD, 8'h12, 32'h5A5A_5A5A, 6'd31);
        send_item(KIND_ENCODE, 8'h12, 32'h0, 6'd0);
        send_item(KIND_ENCODE, 8'h12, 32'h0, 6'd0);
        send_item(KIND_ENCODE, 8'h12, 32'h0, 6'd0);
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);
        // seven-bit code: partial byte on flush
        send_item(KIND_LOAD, 8'hC3, 32'h0000_0055, 6'd7);
        send_item(KIND_ENCODE, 8'hC3, 32'h0, 6'd0);
        send_item(KIND_ENCODE, 8'hC3, 32'h0, 6'd0);
        send_item(KIND_FLUSH, 8'h00, 32'h0, 6'd0);

        // Random part; the receiver holds off once near its start
        hold_req <= 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 75) begin
                // message: load a few codes, encode with them, flush
                msg_syms.delete();
                nload = $urandom_range(1, 6);
                repeat (nload) begin
                    sym = 8'($urandom_range(0, 255));
                    len = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(13, MAX_CODE_LEN))
                                                      : 6'($urandom_range(1, 12));
                    send_item(KIND_LOAD, sym, $urandom, len);
                    msg_syms.insert(msg_syms.size(), sym);
                    sent++;
                end
                nenc = $urandom_range(1, 20);
                repeat (nenc) begin
                    sym = msg_syms[$urandom_range(0, msg_syms.size() - 1)];
                    send_item(KIND_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)));
                    sent++;
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_item(KIND_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                              6'($urandom_range(0, 63)));
                    sent++;
                end
            end else begin
                // noise: any kind with any fields
                pick = $urandom_range(0, 3);
                send_item(pick[1:0], 8'($urandom_range(0, 255)), $urandom,
                          6'($urandom_range(0, 63)));
                if (pick[1:0] != KIND_SPARE)
                    sent++;
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        // drain and verdict
        while (results_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && results_owed == 0)
            $display("tb_huffman_byte_encoder_core OK");
        else
            $display("tb_huffman_byte_encoder_core NOT OK");
        $finish;
    end

endmodule

// ----- huffman_byte_encoder_core.f -----
design/hbe_pkg.sv
design/hbe_code_table.sv
design/hbe_packer.sv
design/hbe_out_buffer.sv
design/huffman_byte_encoder_core.sv
dv/hbe_stream_checker.sv
dv/tb_huffman_byte_encoder_core.sv
